@@ rtl/core/hrhp_pkg.sv @@
// Shared types, constants and method tables for the HTTP request header parser.
// No dependencies; imported by http_request_header_parser_core.
`timescale 1ns / 1ps

package hrhp_pkg;

    // offset and header limits
    localparam int OFFSET_BITS = 16;
    localparam int MAX_HEADERS = 10;
    localparam int HDR_IDX_W   = 4;

    // result kinds
    localparam logic [1:0] KIND_REQ_LINE = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // special characters
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_HT = 8'd9;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;

    // method names, padded with zero bytes
    localparam logic [7:0] METHOD_TEXT [8][8] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] METHOD_LEN [8] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5
    };

    // one input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_request;
    } req_item_t;

    // one parse result
    typedef struct packed {
        logic [1:0]             kind;
        logic [2:0]             method;
        logic [HDR_IDX_W-1:0]   header_index;
        logic [OFFSET_BITS-1:0] span_start;
        logic [OFFSET_BITS-1:0] span_length;
        logic                   body_present;
        logic [HDR_IDX_W-1:0]   header_total;
        logic                   final_res;
    } res_item_t;

    // blank characters inside a line
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

@@ rtl/core/http_request_header_parser_core.sv @@
// HTTP request header parser core: byte stream in, span results out.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps

// Takes one request byte per clock on the req channel while req_ready is high
// and reports the URI span, up to ten indexed header line spans, and a final
// done or error transaction on res, with offsets counted from the first byte
// of each request. Each byte is parsed in the cycle it is accepted and its
// results (at most two) go into a four-entry registered result queue and
// reach res behind any results still waiting. req_ready is high while the
// queue has at least two free entries, so with res taken every cycle the
// block sustains one byte per clock; a byte with two results leaves one to drain.
module http_request_header_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  hrhp_pkg::req_item_t req,
    output logic                res_valid,
    input  logic                res_ready,
    output hrhp_pkg::res_item_t res
);
    import hrhp_pkg::*;

    // parser phases
    localparam logic [2:0] PH_METHOD = 3'd0;
    localparam logic [2:0] PH_GAP    = 3'd1;
    localparam logic [2:0] PH_URI    = 3'd2;
    localparam logic [2:0] PH_REST   = 3'd3;
    localparam logic [2:0] PH_HEAD   = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    localparam int QDEPTH = 4;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             cand_reg, cand_next;
    logic [2:0]             pos_reg, pos_next;
    logic [2:0]             method_reg, method_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] line_start_reg, line_start_next;
    logic [OFFSET_BITS-1:0] uri_start_reg, uri_start_next;
    logic [HDR_IDX_W-1:0]   hdr_seen_reg, hdr_seen_next;
    logic                   cr_reg, cr_next;
    logic                   error_reg, error_next;

    res_item_t              line_res, fin_res;
    logic                   line_valid, fin_valid;

    res_item_t              queue_reg [QDEPTH];
    logic [1:0]             rd_ptr_reg, wr_ptr_reg;
    logic [2:0]             count_reg;
    logic                   req_take, res_take;
    logic [1:0]             push_cnt;

    assign req_ready = (count_reg <= 3'(QDEPTH - 2));
    assign req_take  = req_valid && req_ready;
    assign res_valid = (count_reg != 3'd0);
    assign res_take  = res_valid && res_ready;
    assign res       = queue_reg[rd_ptr_reg];

    // per-byte parse step
    always_comb
    begin
        logic [7:0]             b;
        logic                   eol;
        logic                   err;
        logic [7:0]             cand_keep;
        logic                   found;
        logic [2:0]             found_k;
        logic [OFFSET_BITS-1:0] off;

        b   = req.data_byte;
        off = offset_reg;
        eol = (b == CH_CR) || (b == CH_LF);
        err = error_reg;
        cand_keep = cand_reg;
        found   = 1'b0;
        found_k = 3'd0;

        phase_next      = phase_reg;
        cand_next       = cand_reg;
        pos_next        = pos_reg;
        method_next     = method_reg;
        line_start_next = line_start_reg;
        uri_start_next  = uri_start_reg;
        hdr_seen_next   = hdr_seen_reg;
        cr_next         = cr_reg;

        line_res   = '0;
        fin_res    = '0;
        line_valid = 1'b0;
        fin_valid  = 1'b0;

        // offset overrun
        if (!err && (off == '1))
        begin
            err = 1'b1;
        end

        if (!err)
        begin
            cr_next = 1'b0;
            if (cr_reg && (b == CH_LF))
            begin
                line_start_next = off + 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD:
                    begin
                        // drop candidates that do not match at this position
                        for (int k = 0; k < 8; k++)
                        begin
                            if ({1'b0, pos_reg} >= METHOD_LEN[k] ||
                                METHOD_TEXT[k][pos_reg] != b)
                            begin
                                cand_keep[k] = 1'b0;
                            end
                        end
                        cand_next = cand_keep;
                        // lowest candidate whose name is complete
                        for (int k = 7; k >= 0; k--)
                        begin
                            if (cand_keep[k] && METHOD_LEN[k] == {1'b0, pos_reg} + 4'd1)
                            begin
                                found   = 1'b1;
                                found_k = 3'(k);
                            end
                        end
                        if (cand_keep == 8'd0)
                        begin
                            err = 1'b1;
                        end
                        else if (found)
                        begin
                            method_next = found_k;
                            phase_next  = PH_GAP;
                        end
                        else
                        begin
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    PH_GAP:
                    begin
                        if (eol)
                        begin
                            err = 1'b1;
                        end
                        else if (!is_blank(b))
                        begin
                            uri_start_next = off;
                            phase_next     = PH_URI;
                        end
                    end
                    PH_URI:
                    begin
                        if (eol)
                        begin
                            err = 1'b1;
                        end
                        else if (is_blank(b))
                        begin
                            line_valid           = 1'b1;
                            line_res.kind        = KIND_REQ_LINE;
                            line_res.method      = method_reg;
                            line_res.span_start  = uri_start_reg;
                            line_res.span_length = off - uri_start_reg;
                            phase_next           = PH_REST;
                        end
                    end
                    PH_REST:
                    begin
                        if (eol)
                        begin
                            cr_next         = (b == CH_CR);
                            line_start_next = off + 1'b1;
                            phase_next      = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (eol)
                        begin
                            if (off == line_start_reg)
                            begin
                                phase_next = PH_BODY;
                            end
                            else if (hdr_seen_reg < HDR_IDX_W'(MAX_HEADERS))
                            begin
                                line_valid            = 1'b1;
                                line_res.kind         = KIND_HEADER;
                                line_res.method       = method_reg;
                                line_res.header_index = hdr_seen_reg;
                                line_res.span_start   = line_start_reg;
                                line_res.span_length  = off - line_start_reg;
                                hdr_seen_next         = hdr_seen_reg + 1'b1;
                            end
                            cr_next         = (b == CH_CR);
                            line_start_next = off + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        error_next  = err;
        offset_next = (off != '1) ? off + 1'b1 : off;

        // end of request: final transaction and return to reset state
        if (req.end_of_request)
        begin
            fin_valid         = 1'b1;
            fin_res.final_res = 1'b1;
            if (err || (phase_next < PH_HEAD))
            begin
                fin_res.kind = KIND_ERROR;
            end
            else
            begin
                fin_res.kind         = KIND_DONE;
                fin_res.method       = method_next;
                fin_res.header_total = hdr_seen_next;
                if (phase_next == PH_BODY)
                begin
                    fin_res.span_start   = line_start_next;
                    fin_res.body_present = 1'b1;
                end
            end
            phase_next      = PH_METHOD;
            cand_next       = 8'hFF;
            pos_next        = 3'd0;
            method_next     = 3'd0;
            offset_next     = '0;
            line_start_next = '0;
            uri_start_next  = '0;
            hdr_seen_next   = '0;
            cr_next         = 1'b0;
            error_next      = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            cand_reg       <= 8'hFF;
            pos_reg        <= 3'd0;
            method_reg     <= 3'd0;
            offset_reg     <= '0;
            line_start_reg <= '0;
            uri_start_reg  <= '0;
            hdr_seen_reg   <= '0;
            cr_reg         <= 1'b0;
            error_reg      <= 1'b0;
        end
        else if (req_take)
        begin
            phase_reg      <= phase_next;
            cand_reg       <= cand_next;
            pos_reg        <= pos_next;
            method_reg     <= method_next;
            offset_reg     <= offset_next;
            line_start_reg <= line_start_next;
            uri_start_reg  <= uri_start_next;
            hdr_seen_reg   <= hdr_seen_next;
            cr_reg         <= cr_next;
            error_reg      <= error_next;
        end
    end

    assign push_cnt = req_take ? ({1'b0, line_valid} + {1'b0, fin_valid}) : 2'd0;

    // result queue payload
    always_ff @(posedge clk)
    begin
        if (req_take && line_valid)
        begin
            queue_reg[wr_ptr_reg] <= line_res;
        end
        if (req_take && fin_valid)
        begin
            queue_reg[wr_ptr_reg + {1'b0, line_valid}] <= fin_res;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 2'd0;
            wr_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (res_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push_cnt} - {2'b00, res_take};
        end
    end

endmodule
